// ===== hw/rtl/sfp_pkg.sv =====
// Shared types and constants for the serial frame parser with CRC-16 check.
// Holds the parse phase and status codes and the result record passed
// from the parser core to the top level. No dependencies.
package sfp_pkg;

   localparam int MaxFrameDef = 128;
   localparam int CountW      = 8;

   localparam logic [7:0]  HdrByte0 = 8'h66;
   localparam logic [7:0]  HdrByte1 = 8'h68;
   localparam logic [7:0]  EndByte0 = 8'h5B;
   localparam logic [7:0]  EndByte1 = 8'h81;
   localparam logic [15:0] CrcInit  = 16'hFFFF;
   localparam logic [15:0] CrcPoly  = 16'hA001;

   typedef enum logic [1:0] {
      PhHunt1,
      PhHunt2,
      PhCollect,
      PhAwait
   } phase_type;

   typedef enum logic [1:0] {
      StatOk       = 2'd0,
      StatCrcErr   = 2'd1,
      StatShort    = 2'd2,
      StatOverflow = 2'd3
   } status_type;

   typedef struct packed {
      status_type         frame_status;
      logic [7:0]         frame_type;
      logic [7:0]         command_code;
      logic signed [31:0] word_x;
      logic signed [31:0] word_y;
      logic [7:0]         payload_length;
   } result_type;

endpackage

// ===== hw/rtl/sfp_parser.sv =====
// Frame parser core: header hunt, byte counting, delayed CRC-16 and the
// captured header fields. One byte is consumed per enabled cycle and a
// result record is formed in the same cycle. Depends on sfp_pkg.
module sfp_parser #(
   parameter int MAX_FRAME = sfp_pkg::MaxFrameDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               byte_valid,
   input  logic [7:0]         byte_data,
   output logic               res_valid,
   output sfp_pkg::result_type res
);
   import sfp_pkg::*;

   localparam logic [CountW-1:0] MaxFrameC = CountW'(MAX_FRAME);

   phase_type         phase_ff, phase_in;
   logic [CountW-1:0] count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        tail_ff [4];
   logic [7:0]        hdr_ff [10];
   logic              tail_shift;
   logic              hdr_we;
   logic [3:0]        hdr_idx;
   logic [15:0]       rx_crc;
   logic [CountW-1:0] len;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CrcPoly;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   assign hdr_idx = 4'(count_ff - CountW'(2));
   assign rx_crc  = {tail_ff[2], tail_ff[1]};
   assign len     = count_ff - CountW'(5);

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      tail_shift = 1'b0;
      hdr_we     = 1'b0;
      res_valid  = 1'b0;
      res        = '0;
      if (byte_valid) begin
         unique case (phase_ff)
            PhHunt1: begin
               if (byte_data == HdrByte0) begin
                  phase_in = PhHunt2;
               end
            end
            PhHunt2: begin
               if (byte_data == HdrByte1) begin
                  phase_in = PhCollect;
                  count_in = CountW'(2);
                  crc_in   = CrcInit;
               end else if (byte_data != HdrByte0) begin
                  phase_in = PhHunt1;
               end
            end
            PhCollect, PhAwait: begin
               if (count_ff >= MaxFrameC) begin
                  phase_in               = PhHunt1;
                  count_in               = '0;
                  res_valid              = 1'b1;
                  res.frame_status       = StatOverflow;
                  res.frame_type         = hdr_ff[0];
                  res.command_code       = hdr_ff[1];
                  res.word_x             = {hdr_ff[5], hdr_ff[4], hdr_ff[3], hdr_ff[2]};
                  res.word_y             = {hdr_ff[9], hdr_ff[8], hdr_ff[7], hdr_ff[6]};
               end else begin
                  count_in   = count_ff + CountW'(1);
                  tail_shift = 1'b1;
                  hdr_we     = (count_ff >= CountW'(2)) && (count_ff < CountW'(12));
                  if (count_ff >= CountW'(6)) begin
                     crc_in = crc_byte(crc_ff, tail_ff[0]);
                  end
                  if ((phase_ff == PhAwait) && (byte_data == EndByte1)) begin
                     phase_in  = PhHunt1;
                     count_in  = '0;
                     res_valid = 1'b1;
                     if (count_ff < CountW'(5)) begin
                        res.frame_status = StatShort;
                     end else begin
                        res.frame_status   = (rx_crc == crc_in) ? StatOk : StatCrcErr;
                        res.payload_length = len;
                        if (count_ff >= CountW'(6)) begin
                           res.frame_type = hdr_ff[0];
                        end
                        if (count_ff >= CountW'(7)) begin
                           res.command_code = hdr_ff[1];
                        end
                        if (count_ff >= CountW'(11)) begin
                           res.word_x = {hdr_ff[5], hdr_ff[4], hdr_ff[3], hdr_ff[2]};
                        end
                        if (count_ff >= CountW'(15)) begin
                           res.word_y = {hdr_ff[9], hdr_ff[8], hdr_ff[7], hdr_ff[6]};
                        end
                     end
                  end else begin
                     phase_in = (byte_data == EndByte0) ? PhAwait : PhCollect;
                  end
               end
            end
            default: begin
               phase_in = PhHunt1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhHunt1;
         count_ff <= '0;
         crc_ff   <= CrcInit;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_shift) begin
         for (int i = 0; i < 3; i++) begin
            tail_ff[i] <= tail_ff[i+1];
         end
         tail_ff[3] <= byte_data;
      end
      if (hdr_we) begin
         hdr_ff[hdr_idx] <= byte_data;
      end
   end

endmodule

// ===== hw/rtl/serial_frame_parser_crc16.sv =====
// Top level of the serial frame parser with CRC-16 check: input byte
// register, parser core and result register with valid/ready handshakes.
// Depends on sfp_pkg and sfp_parser.
//
//   channel  direction  payload
//   req_     in         rx_byte (8 bit)
//   rsp_     out        frame_status, frame_type, command_code, word_x,
//                       word_y, payload_length
//
// One byte per cycle is sustained while results are taken: a byte is held
// in the input register and its result, if any, is registered in the
// result register. The parser core does header hunt, CRC-16 and field
// capture combinationally between the two registers. Reset is synchronous
// and clears both valid flags and the parse state. A stalled result holds
// the input register, which then holds req_ready low.
module serial_frame_parser_crc16 #(
   parameter int MAX_FRAME = sfp_pkg::MaxFrameDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_frame_status,
   output logic [7:0]         rsp_frame_type,
   output logic [7:0]         rsp_command_code,
   output logic signed [31:0] rsp_word_x,
   output logic signed [31:0] rsp_word_y,
   output logic [7:0]         rsp_payload_length
);
   import sfp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   logic       advance;
   logic       res_valid;
   result_type res;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sfp_parser #(
      .MAX_FRAME(MAX_FRAME)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (advance),
      .byte_data  (in_byte_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = res_valid;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance && res_valid) begin
         out_ff <= res;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_status   = 2'(out_ff.frame_status);
   assign rsp_frame_type     = out_ff.frame_type;
   assign rsp_command_code   = out_ff.command_code;
   assign rsp_word_x         = out_ff.word_x;
   assign rsp_word_y         = out_ff.word_y;
   assign rsp_payload_length = out_ff.payload_length;

endmodule
